/* design/fpr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpr_pkg
// Shared types and constants for the float pixel to rgba8 converter.
// ----------------------------------------------------------------------------
package fpr_pkg;

  localparam int unsigned NumLanes = 4;

  // configuration register indexes
  localparam logic [1:0] RegChannelCount = 2'd0;
  localparam logic [1:0] RegForceOpaque  = 2'd1;
  localparam logic [1:0] RegHalfInput    = 2'd2;

  localparam logic [7:0] ByteMax = 8'hFF;
  localparam logic [7:0] ByteMin = 8'h00;

  typedef struct packed {
    logic [2:0] channel_count;
    logic       force_opaque;
    logic       half_input;
  } cfg_t;

endpackage

/* design/float_pixel_to_rgba8.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// float_pixel_to_rgba8
// Converts one pixel of up to four float channels to four unorm8 bytes.
// ----------------------------------------------------------------------------
// Usage:
//   input channel: in_valid / in_stall with chan_a..chan_d and last_in;
//   a pixel transfers when in_valid is high and in_stall is low.
//   output channel: out_valid / out_stall with byte_r..byte_a and last_out.
//   config channel: cfg_valid / cfg_ready, cfg_index selects channel_count,
//   force_opaque or half_input; cfg_ready is always high. Write it only
//   while no pixel is in flight.
// One pixel is taken every cycle while in_stall is low: four lanes run
// side by side through a two-stage multiply and round core, followed by
// the merge register.
// Reset clears all stage valids and loads channel_count 3, opaque off,
// binary32 input. When the receiver stalls the stages fill up in turn and
// in_stall rises once the first stage is also full.
// ----------------------------------------------------------------------------
module float_pixel_to_rgba8 (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] chan_a,
  input  logic [31:0] chan_b,
  input  logic [31:0] chan_c,
  input  logic [31:0] chan_d,
  input  logic        last_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  byte_r,
  output logic [7:0]  byte_g,
  output logic [7:0]  byte_b,
  output logic [7:0]  byte_a,
  output logic        last_out,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [2:0]  cfg_data
);

  fpr_pkg::cfg_t cfg;
  logic          v1;
  logic          v2;
  logic          last1;
  logic          last2;
  logic          rdy1;
  logic          rdy2;
  logic          rdy3;
  logic [7:0]    lane_byte [fpr_pkg::NumLanes];
  logic [31:0]   lane_word [fpr_pkg::NumLanes];

  assign cfg_ready = 1'b1;
  assign rdy3      = !out_valid || !out_stall;
  assign rdy2      = !v2 || rdy3;
  assign rdy1      = !v1 || rdy2;
  assign in_stall  = !rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.channel_count <= 3'd3;
      cfg.force_opaque  <= 1'b0;
      cfg.half_input    <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        fpr_pkg::RegChannelCount: cfg.channel_count <= cfg_data;
        fpr_pkg::RegForceOpaque:  cfg.force_opaque  <= cfg_data[0];
        fpr_pkg::RegHalfInput:    cfg.half_input    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy1) begin
        v1 <= in_valid;
      end
      if (rdy2) begin
        v2 <= v1;
      end
      if (rdy3) begin
        out_valid <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      last1 <= last_in;
    end
    if (rdy2) begin
      last2 <= last1;
    end
  end

  assign lane_word[0] = chan_a;
  assign lane_word[1] = chan_b;
  assign lane_word[2] = chan_c;
  assign lane_word[3] = chan_d;

  for (genvar i = 0; i < fpr_pkg::NumLanes; i++) begin : g_lane
    fpr_lane u_lane (
      .clk    (clk),
      .en1    (rdy1),
      .en2    (rdy2),
      .half   (cfg.half_input),
      .word   (lane_word[i]),
      .byte_q (lane_byte[i])
    );
  end

  fpr_merge u_merge (
    .clk      (clk),
    .en       (rdy3),
    .cfg      (cfg),
    .lane0    (lane_byte[0]),
    .lane1    (lane_byte[1]),
    .lane2    (lane_byte[2]),
    .lane3    (lane_byte[3]),
    .last_d   (last2),
    .byte_r   (byte_r),
    .byte_g   (byte_g),
    .byte_b   (byte_b),
    .byte_a   (byte_a),
    .last_out (last_out)
  );

  // an empty output register never holds back the input side
  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

  // a transferred pixel always lands in the first stage
  a_accept_fills_stage: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> v1)
    else $error("accepted pixel lost");

  // a full middle stage moves on whenever the output can take it
  a_mid_advance: assert property (@(posedge clk) disable iff (rst)
    (v2 && !out_stall) |=> out_valid)
    else $error("middle stage did not advance");

endmodule

/* design/fpr_lane.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpr_lane
// One channel core: decode, clamp and scale by 255 with binary32 rounding,
// then truncate to a byte. Two register stages.
// ----------------------------------------------------------------------------
module fpr_lane (
  input  logic        clk,
  input  logic        en1,
  input  logic        en2,
  input  logic        half,
  input  logic [31:0] word,
  output logic [7:0]  byte_q
);

  logic        sgn;
  logic [7:0]  ex;
  logic [22:0] frac;
  logic [4:0]  hex;
  logic        nan_c;
  logic        big_c;
  logic        zero_c;

  logic [31:0] prod;
  logic [7:0]  ex1;
  logic        big1;
  logic        zero1;

  logic        lead;
  logic [23:0] q;
  logic        rnd;
  logic [24:0] qr;
  logic [7:0]  sh;
  logic [24:0] shifted;
  logic [7:0]  byte_next;

  always_comb begin
    hex = word[14:10];
    if (half) begin
      sgn = word[15];
      if (hex == 5'd31) begin
        ex = 8'hFF;
      end else if (hex == 5'd0) begin
        // half subnormals stay far below one after scaling
        ex = 8'd0;
      end else begin
        ex = {3'b000, hex} + 8'd112;
      end
      frac = {word[9:0], 13'd0};
    end else begin
      sgn  = word[31];
      ex   = word[30:23];
      frac = word[22:0];
    end
    nan_c  = (ex == 8'hFF) && (frac != 23'd0);
    big_c  = !nan_c && !sgn && ((ex > 8'd127) || ((ex == 8'd127) && (frac != 23'd0)));
    zero_c = nan_c || sgn || (ex == 8'd0);
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      prod  <= 32'({1'b1, frac}) * 32'd255;
      ex1   <= ex;
      big1  <= big_c;
      zero1 <= zero_c;
    end
  end

  // round the exact product to 24 significant bits, nearest even
  always_comb begin
    lead = prod[31];
    if (lead) begin
      q   = prod[31:8];
      rnd = prod[7] && ((prod[6:0] != 7'd0) || prod[8]);
      sh  = 8'd142 - ex1;
    end else begin
      q   = prod[30:7];
      rnd = prod[6] && ((prod[5:0] != 6'd0) || prod[7]);
      sh  = 8'd143 - ex1;
    end
    qr      = {1'b0, q} + {24'd0, rnd};
    shifted = (sh >= 8'd25) ? 25'd0 : (qr >> sh[4:0]);
    if (big1) begin
      byte_next = fpr_pkg::ByteMax;
    end else if (zero1) begin
      byte_next = fpr_pkg::ByteMin;
    end else begin
      byte_next = shifted[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      byte_q <= byte_next;
    end
  end

endmodule

/* design/fpr_merge.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpr_merge
// Combines the lane bytes: copies byte 0 into absent channels and applies
// the opaque override, into the output register.
// ----------------------------------------------------------------------------
module fpr_merge (
  input  logic           clk,
  input  logic           en,
  input  fpr_pkg::cfg_t  cfg,
  input  logic [7:0]     lane0,
  input  logic [7:0]     lane1,
  input  logic [7:0]     lane2,
  input  logic [7:0]     lane3,
  input  logic           last_d,
  output logic [7:0]     byte_r,
  output logic [7:0]     byte_g,
  output logic [7:0]     byte_b,
  output logic [7:0]     byte_a,
  output logic           last_out
);

  logic       has_g;
  logic       has_b;
  logic       has_a;

  always_comb begin
    has_g = (cfg.channel_count >= 3'd2);
    has_b = (cfg.channel_count >= 3'd3);
    has_a = (cfg.channel_count >= 3'd4);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      byte_r   <= lane0;
      byte_g   <= has_g ? lane1 : lane0;
      byte_b   <= has_b ? lane2 : lane0;
      byte_a   <= cfg.force_opaque ? fpr_pkg::ByteMax : (has_a ? lane3 : lane0);
      last_out <= last_d;
    end
  end

endmodule
